// File: sv/mvrt_pkg.sv
package mvrt_pkg;

   localparam int MAX_PROCS_DEF    = 16;
   localparam int RUNTIME_BITS_DEF = 32;
   localparam int STAMP_W          = 32;
   localparam int MODE_W           = 2;
   localparam int ID_W             = 4;
   localparam int TICK_CHARGE      = 10;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_SCHED  = 2'd3
   } mode_type;

endpackage

// File: sv/mvrt_slot_mem.sv
module mvrt_slot_mem #(
   parameter int DEPTH = mvrt_pkg::MAX_PROCS_DEF,
   parameter int RT_W  = mvrt_pkg::RUNTIME_BITS_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rt_we,
   input  logic                       st_we,
   input  logic [IDX_W-1:0]           waddr,
   input  logic [RT_W-1:0]            rt_wdata,
   input  logic [mvrt_pkg::STAMP_W-1:0] st_wdata,
   input  logic [IDX_W-1:0]           raddr,
   output logic [RT_W-1:0]            rt_rdata,
   output logic [mvrt_pkg::STAMP_W-1:0] st_rdata
);
   import mvrt_pkg::*;

   logic [RT_W-1:0]    rt_mem [DEPTH];
   logic [STAMP_W-1:0] st_mem [DEPTH];
   logic [DEPTH-1:0]   rt_written_ff;
   logic [RT_W-1:0]    rt_rd_ff;
   logic               rt_ok_ff;
   logic [STAMP_W-1:0] st_rd_ff;

   always_ff @(posedge clock) begin
      if (rt_we) begin
         rt_mem[waddr] <= rt_wdata;
      end
      if (st_we) begin
         st_mem[waddr] <= st_wdata;
      end
      rt_rd_ff <= rt_mem[raddr];
      st_rd_ff <= st_mem[raddr];
   end

   // runtime entries read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         rt_written_ff <= '0;
         rt_ok_ff      <= 1'b0;
      end else begin
         if (rt_we) begin
            rt_written_ff[waddr] <= 1'b1;
         end
         rt_ok_ff <= rt_written_ff[raddr];
      end
   end

   assign rt_rdata = rt_ok_ff ? rt_rd_ff : '0;
   assign st_rdata = st_rd_ff;

endmodule

// File: sv/mvrt_picker.sv
module mvrt_picker #(
   parameter int RT_W  = mvrt_pkg::RUNTIME_BITS_DEF,
   parameter int IDX_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         cand_valid,
   input  logic                         cand_ok,
   input  logic [IDX_W-1:0]             cand_idx,
   input  logic [RT_W-1:0]              cand_rt,
   input  logic [mvrt_pkg::STAMP_W-1:0] cand_stamp,
   input  logic [mvrt_pkg::STAMP_W-1:0] add_count,
   output logic                         found,
   output logic [IDX_W-1:0]             best_idx,
   output logic                         best_rt_zero
);
   import mvrt_pkg::*;

   logic               found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [RT_W-1:0]    best_rt_ff;
   logic [STAMP_W-1:0] best_age_ff;
   logic [STAMP_W-1:0] cand_age;
   logic               better;

   // age wraps with the add counter
   assign cand_age = add_count - cand_stamp;
   assign better   = cand_valid && cand_ok &&
                     (!found_ff || (cand_rt < best_rt_ff) ||
                      ((cand_rt == best_rt_ff) && (cand_age < best_age_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (clear) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
      if (better) begin
         best_idx_ff <= cand_idx;
         best_rt_ff  <= cand_rt;
         best_age_ff <= cand_age;
      end
   end

   assign found        = found_ff;
   assign best_idx     = best_idx_ff;
   assign best_rt_zero = (best_rt_ff == '0);

endmodule

// File: sv/min_vruntime_process_picker.sv
// channel  | direction | ports                                         | transfer
// ---------+-----------+-----------------------------------------------+----------------
// req      | in        | req_mode, req_proc_id                         | valid & ready
// rsp      | out       | rsp_switched, rsp_chosen_id, rsp_first_start, | valid & ready
//          |           | rsp_running_valid, rsp_running_id             |
//
// add and remove go to done directly; schedule scans all slots, a tick on a running
// slot charges it, then scans: the scan reads one slot a cycle from the slot memory.
// synchronous reset clears flags, counters and the runtime written bits at once.
// a result waits in its output register; the next request is taken meanwhile,
// and the block only stalls when a new result finds that register still full.
module min_vruntime_process_picker #(
   parameter int MAX_PROCS    = mvrt_pkg::MAX_PROCS_DEF,
   parameter int RUNTIME_BITS = mvrt_pkg::RUNTIME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mvrt_pkg::MODE_W-1:0] req_mode,
   input  logic [mvrt_pkg::ID_W-1:0]   req_proc_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_switched,
   output logic [mvrt_pkg::ID_W-1:0]   rsp_chosen_id,
   output logic                        rsp_first_start,
   output logic                        rsp_running_valid,
   output logic [mvrt_pkg::ID_W-1:0]   rsp_running_id
);
   import mvrt_pkg::*;

   localparam int IDX_W = $clog2(MAX_PROCS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK_WR,
      S_SCAN,
      S_LAST,
      S_DONE
   } state_type;

   state_type          state_ff;
   mode_type           op_mode_ff;
   logic [ID_W-1:0]    op_id_ff;
   logic               pick_run_ff;
   logic [IDX_W-1:0]   scan_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [MAX_PROCS-1:0] present_ff;
   logic [MAX_PROCS-1:0] running_ff;
   logic [STAMP_W-1:0] add_count_ff;
   logic               cur_valid_ff;
   logic [IDX_W-1:0]   cur_slot_ff;
   logic               rsp_valid_ff;
   logic               rsp_switched_ff;
   logic [ID_W-1:0]    rsp_chosen_id_ff;
   logic               rsp_first_start_ff;
   logic               rsp_running_valid_ff;
   logic [ID_W-1:0]    rsp_running_id_ff;

   logic               req_xfer;
   logic               out_free;
   logic               done_go;
   logic               op_in_range;
   logic [IDX_W-1:0]   op_idx;
   logic               tickable;
   logic [RUNTIME_BITS:0] tick_sum;
   logic [RUNTIME_BITS-1:0] tick_rt;

   logic               rt_we;
   logic               st_we;
   logic [IDX_W-1:0]   waddr;
   logic [RUNTIME_BITS-1:0] rt_wdata;
   logic [IDX_W-1:0]   raddr;
   logic [RUNTIME_BITS-1:0] rt_rdata;
   logic [STAMP_W-1:0] st_rdata;

   logic               pk_found;
   logic [IDX_W-1:0]   pk_idx;
   logic               pk_rt_zero;
   logic               picked;
   logic               cur_valid_in;
   logic [IDX_W-1:0]   cur_slot_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_xfer    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign done_go     = (state_ff == S_DONE) && out_free;
   assign op_in_range = (32'(op_id_ff) < 32'(MAX_PROCS));
   assign op_idx      = IDX_W'(op_id_ff);
   assign tickable    = cur_valid_ff && running_ff[cur_slot_ff];

   // saturating charge of the running slot
   assign tick_sum = {1'b0, rt_rdata} + (RUNTIME_BITS + 1)'(TICK_CHARGE);
   assign tick_rt  = tick_sum[RUNTIME_BITS] ? '1 : tick_sum[RUNTIME_BITS-1:0];

   assign picked       = pick_run_ff && pk_found;
   assign cur_valid_in = cur_valid_ff || picked;
   assign cur_slot_in  = picked ? pk_idx : cur_slot_ff;

   assign raddr = (state_ff == S_SCAN) ? scan_ff : cur_slot_ff;

   always_comb begin
      rt_we    = 1'b0;
      st_we    = 1'b0;
      waddr    = cur_slot_ff;
      rt_wdata = tick_rt;
      if (state_ff == S_TICK_WR) begin
         rt_we = 1'b1;
      end else if (done_go) begin
         if (picked) begin
            waddr    = pk_idx;
            rt_we    = pk_rt_zero;
            rt_wdata = RUNTIME_BITS'(1);
         end else if (op_mode_ff == MODE_ADD && op_in_range) begin
            waddr = op_idx;
            st_we = 1'b1;
         end
      end
   end

   mvrt_slot_mem #(
      .DEPTH (MAX_PROCS),
      .RT_W  (RUNTIME_BITS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rt_we    (rt_we),
      .st_we    (st_we),
      .waddr    (waddr),
      .rt_wdata (rt_wdata),
      .st_wdata (add_count_ff + STAMP_W'(1)),
      .raddr    (raddr),
      .rt_rdata (rt_rdata),
      .st_rdata (st_rdata)
   );

   mvrt_picker #(
      .RT_W  (RUNTIME_BITS),
      .IDX_W (IDX_W)
   ) u_picker (
      .clock        (clock),
      .reset        (reset),
      .clear        (req_xfer),
      .cand_valid   (cmp_vld_ff),
      .cand_ok      (present_ff[cmp_idx_ff] && !running_ff[cmp_idx_ff]),
      .cand_idx     (cmp_idx_ff),
      .cand_rt      (rt_rdata),
      .cand_stamp   (st_rdata),
      .add_count    (add_count_ff),
      .found        (pk_found),
      .best_idx     (pk_idx),
      .best_rt_zero (pk_rt_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pick_run_ff  <= 1'b0;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         present_ff   <= '0;
         running_ff   <= '0;
         add_count_ff <= '0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         cmp_vld_ff <= (state_ff == S_SCAN);
         cmp_idx_ff <= scan_ff;
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  op_mode_ff  <= mode_type'(req_mode);
                  op_id_ff    <= req_proc_id;
                  scan_ff     <= '0;
                  pick_run_ff <= (mode_type'(req_mode) == MODE_SCHED);
                  unique case (mode_type'(req_mode))
                     MODE_TICK: begin
                        // read issued now for the charge next cycle
                        state_ff <= tickable ? S_TICK_WR : S_DONE;
                     end
                     MODE_SCHED: begin
                        state_ff <= S_SCAN;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_TICK_WR: begin
               pick_run_ff <= 1'b1;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               scan_ff <= IDX_W'(scan_ff + 1'b1);
               if (scan_ff == IDX_W'(MAX_PROCS - 1)) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff             <= S_IDLE;
                  rsp_switched_ff      <= picked;
                  rsp_chosen_id_ff     <= picked ? ID_W'(pk_idx) : '0;
                  rsp_first_start_ff   <= picked && pk_rt_zero;
                  rsp_running_valid_ff <= cur_valid_in;
                  rsp_running_id_ff    <= cur_valid_in ? ID_W'(cur_slot_in) : '0;
                  cur_valid_ff         <= cur_valid_in;
                  cur_slot_ff          <= cur_slot_in;
                  if (picked) begin
                     // old runner back to ready, new one marked running
                     running_ff <= (running_ff &
                                    ~(MAX_PROCS'(cur_valid_ff) << cur_slot_ff)) |
                                   (MAX_PROCS'(1) << pk_idx);
                  end else if (op_in_range) begin
                     if (op_mode_ff == MODE_ADD) begin
                        present_ff[op_idx] <= 1'b1;
                        running_ff[op_idx] <= 1'b0;
                        add_count_ff       <= add_count_ff + STAMP_W'(1);
                     end else if (op_mode_ff == MODE_REMOVE) begin
                        present_ff[op_idx] <= 1'b0;
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_chosen_id     = rsp_chosen_id_ff;
   assign rsp_first_start   = rsp_first_start_ff;
   assign rsp_running_valid = rsp_running_valid_ff;
   assign rsp_running_id    = rsp_running_id_ff;

`ifndef SYNTHESIS
   a_one_runner: assert property (@(posedge clock) disable iff (reset)
      $onehot0(running_ff))
      else $error("more than one slot marked running");

   a_runner_is_current: assert property (@(posedge clock) disable iff (reset)
      $onehot(running_ff) |-> cur_valid_ff && running_ff[cur_slot_ff])
      else $error("running slot is not the current slot");

   a_switch_sets_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> rsp_running_valid && rsp_running_id == rsp_chosen_id)
      else $error("switched result does not report the chosen slot as running");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");
`endif

endmodule
